[sv/tolerance_stream_compare_unit_assert.svh]
// assertion macros for the tolerance stream compare unit
// expects clk and rst_n in the scope where the macros are used
`ifndef TOLERANCE_STREAM_COMPARE_UNIT_ASSERT_SVH
`define TOLERANCE_STREAM_COMPARE_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define TSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsc assertion failed");

// consequent checked in the cycle after the antecedent
`define TSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsc assertion failed");

`endif

[sv/tsc_pkg.sv]
// shared types and constants for the tolerance stream compare unit
// no dependencies
package tsc_pkg;

  localparam int INDEX_BITS     = 32;
  localparam int VALUE_BITS     = 32;
  localparam int OUT_INDEX_BITS = 32;
  localparam int ABS_TOL_BITS   = 31;
  localparam int REL_TOL_BITS   = 16;
  localparam int REL_FRAC_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 31;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ABS_TOL = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REL_TOL = 1'b1;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] ref_value;
    logic signed [VALUE_BITS-1:0] test_value;
    logic                         last_element;
  } pair_t;

endpackage

[sv/tsc_pair_check.sv]
// tolerance test for one reference/test pair, pure combinational
// depends on tsc_pkg
module tsc_pair_check (
  input  tsc_pkg::pair_t                     pair,
  input  logic [tsc_pkg::ABS_TOL_BITS-1:0]   abs_tol,
  input  logic [tsc_pkg::REL_TOL_BITS-1:0]   rel_tol,
  output logic                               fails
);
  import tsc_pkg::*;

  localparam int DIFF_BITS = VALUE_BITS + 1;
  localparam int LHS_BITS  = DIFF_BITS + REL_FRAC_BITS;
  localparam int PROD_BITS = REL_TOL_BITS + VALUE_BITS;

  logic signed [DIFF_BITS-1:0] diff_s;
  logic        [DIFF_BITS-1:0] diff_mag;
  logic        [VALUE_BITS-1:0] ref_mag;
  logic        [LHS_BITS-1:0]  lhs;
  logic        [PROD_BITS-1:0] rhs;
  logic                        over_abs;
  logic                        over_rel;

  always_comb begin
    diff_s   = DIFF_BITS'(pair.ref_value) - DIFF_BITS'(pair.test_value);
    diff_mag = diff_s[DIFF_BITS-1] ? DIFF_BITS'(-diff_s) : DIFF_BITS'(diff_s);
    // magnitude of the most negative value still fits unsigned
    ref_mag  = pair.ref_value[VALUE_BITS-1] ? VALUE_BITS'(-pair.ref_value)
                                            : VALUE_BITS'(pair.ref_value);
    lhs      = {diff_mag, {REL_FRAC_BITS{1'b0}}};
    rhs      = PROD_BITS'(rel_tol) * PROD_BITS'(ref_mag);
    over_abs = diff_mag > DIFF_BITS'(abs_tol);
    over_rel = lhs > LHS_BITS'(rhs);
    fails    = over_abs && over_rel;
  end

endmodule

[sv/tsc_stream_state.sv]
// stream tracking: element index, first failure capture and result register
// depends on tsc_pkg and the assertion macro header
`include "tolerance_stream_compare_unit_assert.svh"

module tsc_stream_state (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   step,
  input  tsc_pkg::pair_t                         pair,
  input  logic                                   pair_fails,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic                                   out_all_close,
  output logic [tsc_pkg::OUT_INDEX_BITS-1:0]     out_fail_index,
  output logic signed [tsc_pkg::VALUE_BITS-1:0]  out_bad_ref_value,
  output logic signed [tsc_pkg::VALUE_BITS-1:0]  out_bad_test_value
);
  import tsc_pkg::*;

  logic [INDEX_BITS-1:0]        element_index_r, element_index_nxt;
  logic                         failure_seen_r, failure_seen_nxt;
  logic [INDEX_BITS-1:0]        captured_index_r, captured_index_nxt;
  logic signed [VALUE_BITS-1:0] captured_ref_r, captured_ref_nxt;
  logic signed [VALUE_BITS-1:0] captured_test_r, captured_test_nxt;
  logic                         new_fail;

  logic                         out_valid_r;
  logic                         out_all_close_r;
  logic [OUT_INDEX_BITS-1:0]    out_index_r;
  logic signed [VALUE_BITS-1:0] out_ref_r;
  logic signed [VALUE_BITS-1:0] out_test_r;

  always_comb begin
    new_fail           = !failure_seen_r && pair_fails;
    failure_seen_nxt   = failure_seen_r || new_fail;
    captured_index_nxt = new_fail ? element_index_r : captured_index_r;
    captured_ref_nxt   = new_fail ? pair.ref_value : captured_ref_r;
    captured_test_nxt  = new_fail ? pair.test_value : captured_test_r;
    element_index_nxt  = element_index_r + INDEX_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_index_r  <= '0;
      failure_seen_r   <= 1'b0;
      captured_index_r <= '0;
      captured_ref_r   <= '0;
      captured_test_r  <= '0;
    end else if (step) begin
      if (pair.last_element) begin
        // stream ends here, start clean for the next one
        element_index_r  <= '0;
        failure_seen_r   <= 1'b0;
        captured_index_r <= '0;
        captured_ref_r   <= '0;
        captured_test_r  <= '0;
      end else begin
        element_index_r  <= element_index_nxt;
        failure_seen_r   <= failure_seen_nxt;
        captured_index_r <= captured_index_nxt;
        captured_ref_r   <= captured_ref_nxt;
        captured_test_r  <= captured_test_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && pair.last_element) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && pair.last_element) begin
      out_all_close_r <= !failure_seen_nxt;
      out_index_r     <= failure_seen_nxt ? OUT_INDEX_BITS'(captured_index_nxt) : '0;
      out_ref_r       <= failure_seen_nxt ? captured_ref_nxt : '0;
      out_test_r      <= failure_seen_nxt ? captured_test_nxt : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_all_close      = out_all_close_r;
  assign out_fail_index     = out_index_r;
  assign out_bad_ref_value  = out_ref_r;
  assign out_bad_test_value = out_test_r;

  `TSC_ASSERT_NEXT(a_last_gives_result, step && pair.last_element, out_valid_r)
  `TSC_ASSERT_NEXT(a_last_clears_stream, step && pair.last_element,
                   !failure_seen_r && element_index_r == '0)
  `TSC_ASSERT_NEXT(a_capture_holds, failure_seen_r && !(step && pair.last_element),
                   failure_seen_r && $stable(captured_index_r) && $stable(captured_ref_r))
  `TSC_ASSERT_SAME(a_clean_result_zero, out_valid_r && out_all_close_r,
                   out_index_r == '0 && out_ref_r == '0 && out_test_r == '0)

endmodule

[sv/tolerance_stream_compare_unit.sv]
// a result is offered from the result register once its last pair has passed the input register and the compare
// throughput: one pair per cycle unless a last pair waits on a stalled result, set by the
// input register feeding the single 16x32 multiply and compare ahead of the result register
// reset: synchronous active-low rst_n clears both tolerances to 0, the
// element index and the failure capture; no result is pending after reset
module tolerance_stream_compare_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [tsc_pkg::VALUE_BITS-1:0]  in_ref_value,
  input  logic signed [tsc_pkg::VALUE_BITS-1:0]  in_test_value,
  input  logic                                   in_last_element,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_all_close,
  output logic [tsc_pkg::OUT_INDEX_BITS-1:0]     out_fail_index,
  output logic signed [tsc_pkg::VALUE_BITS-1:0]  out_bad_ref_value,
  output logic signed [tsc_pkg::VALUE_BITS-1:0]  out_bad_test_value,
  input  logic                                   cfg_we,
  input  logic [tsc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [tsc_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);
  import tsc_pkg::*;

  logic [ABS_TOL_BITS-1:0] abs_tol_r;
  logic [REL_TOL_BITS-1:0] rel_tol_r;
  logic                    s1_valid_r;
  pair_t                   s1_pair_r;
  logic                    s1_step;
  logic                    s1_fails;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_tol_r <= '0;
      rel_tol_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ABS_TOL: abs_tol_r <= ABS_TOL_BITS'(cfg_wdata);
        CFG_REL_TOL: rel_tol_r <= REL_TOL_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // a non-last pair never waits; a last pair waits only for a free result slot
  assign s1_step  = s1_valid_r && (!s1_pair_r.last_element || !out_valid || !out_stall);
  assign in_stall = s1_valid_r && !s1_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_pair_r.ref_value    <= in_ref_value;
      s1_pair_r.test_value   <= in_test_value;
      s1_pair_r.last_element <= in_last_element;
    end
  end

  tsc_pair_check u_check (
    .pair    (s1_pair_r),
    .abs_tol (abs_tol_r),
    .rel_tol (rel_tol_r),
    .fails   (s1_fails)
  );

  tsc_stream_state u_state (
    .clk                (clk),
    .rst_n              (rst_n),
    .step               (s1_step),
    .pair               (s1_pair_r),
    .pair_fails         (s1_fails),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_all_close      (out_all_close),
    .out_fail_index     (out_fail_index),
    .out_bad_ref_value  (out_bad_ref_value),
    .out_bad_test_value (out_bad_test_value)
  );

endmodule
